// ===== rtl/vno_pkg.sv =====
// ---------------------------------------------------------------------------
// vno_pkg
// Shared types, widths, weight table and blend arithmetic for the 3D value
// noise octave summer.
// ---------------------------------------------------------------------------
package vno_pkg;

  // Field widths
  localparam int COORD_XY_W = 26;
  localparam int COORD_Z_W  = 21;
  localparam int LD_OCT_W   = 3;
  localparam int LD_IDX_W   = 15;
  localparam int VAL_W      = 16;
  localparam int NOISE_W    = 19;
  localparam int OCT_CNT_W  = 4;
  localparam int FREQ_W     = 24;
  localparam int FRAC_W     = 16;

  // Lattice geometry: 32 per side, split into 8 banks by corner parity
  localparam int LAT_BITS   = 5;
  localparam int NBANK      = 8;
  localparam int BANK_AW    = 3 * (LAT_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Coordinate product: low half and high half of the coordinate
  localparam int HALF_W     = COORD_XY_W / 2;
  localparam int PROD_W     = FRAC_W + LAT_BITS + FRAC_W;

  // Octave lanes
  localparam int MAX_OCTAVES_DEF = 8;

  // Configuration register indices
  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_BASE_FREQ    = 1'b1;

  // Reset values
  localparam logic [OCT_CNT_W-1:0] OCT_CNT_RST = 4'd1;
  localparam logic [FREQ_W-1:0]    FREQ_RST    = 24'h010000;

  // Output saturation limits
  localparam int NOISE_MAX = 262143;
  localparam int NOISE_MIN = -262144;

  // Cosine weight table
  localparam int COS_BITS  = 8;
  localparam int COS_DEPTH = 1 << COS_BITS;
  localparam int W_W       = 17;

  typedef logic [W_W-1:0] wtab_t [COS_DEPTH];

  // (1 + cos(pi*k/depth))/2 in Q1.16 via a Q30 odd sine series
  function automatic logic [W_W-1:0] cos_weight(int k);
    longint q30;
    longint pi_q30;
    longint num;
    longint u;
    longint m;
    longint u2;
    longint t;
    longint s;
    longint w;
    q30    = 64'd1073741824;
    pi_q30 = 64'd3373259426;
    num    = 2 * longint'(k) - longint'(COS_DEPTH);
    u      = (pi_q30 * num) / (2 * COS_DEPTH);
    m      = (u < 0) ? -u : u;
    u2     = (m * m) >> 30;
    t      = q30 - u2 / 110;
    t      = q30 - ((u2 * t) >> 30) / 72;
    t      = q30 - ((u2 * t) >> 30) / 42;
    t      = q30 - ((u2 * t) >> 30) / 20;
    t      = q30 - ((u2 * t) >> 30) / 6;
    s      = (m * t) >> 30;
    if (u < 0) s = -s;
    w = q30 - s + 16384;
    if (w < 0) w = 0;
    w = w / 32768;
    if (w > 65536) w = 65536;
    return W_W'(w);
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t tab;
    for (int k = 0; k < COS_DEPTH; k++) begin
      tab[k] = cos_weight(k);
    end
    return tab;
  endfunction

  localparam wtab_t WEIGHT_TAB = build_wtab();

  // b + floor((a - b) * w / 2^16 + 1/2); stays within [a, b]
  function automatic logic signed [VAL_W-1:0] blend(logic signed [VAL_W-1:0] a,
                                                    logic signed [VAL_W-1:0] b,
                                                    logic [W_W-1:0] w);
    logic signed [VAL_W:0]   d;
    logic signed [2*W_W:0]   p;
    logic signed [2*W_W:0]   q;
    d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    p = d * $signed({1'b0, w});
    q = (p + (2*W_W+1)'(32768)) >>> FRAC_W;
    q = q + {{(2*W_W+1-VAL_W){b[VAL_W-1]}}, b};
    return q[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/vno_if.sv =====
// ---------------------------------------------------------------------------
// vno_in_if / vno_out_if
// Valid/ready channels carrying the input word and the result word.
// ---------------------------------------------------------------------------
interface vno_in_if;
  import vno_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [LD_OCT_W-1:0]          load_octave;
  logic [LD_IDX_W-1:0]          load_index;
  logic signed [VAL_W-1:0]      load_value;
  logic [COORD_XY_W-1:0]        coord_x;
  logic [COORD_XY_W-1:0]        coord_y;
  logic [COORD_Z_W-1:0]         coord_z;

  modport source (output valid, func, load_octave, load_index, load_value,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, func, load_octave, load_index, load_value,
                  coord_x, coord_y, coord_z, output ready);
endinterface

interface vno_out_if;
  import vno_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [NOISE_W-1:0]    noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== rtl/value_noise_3d_octave_sum.sv =====
// ---------------------------------------------------------------------------
// value_noise_3d_octave_sum
// Multi-octave 3D value noise with cosine blending over banked lattices.
// ---------------------------------------------------------------------------
// One word (lattice load or noise sample) is taken every clock unless the
// output stalls; the pipeline sustains one result per clock while the
// receiver is ready. Each octave has its own lane; its 32x32x32 lattice is
// split into 8 banks by the parity of x, y and z, so the 8 corners of a cell
// are read from 8 different single-port banks in one cycle. A load writes its
// word in the same stage that samples read, so a sample sees every load
// accepted before it. Lattice words must be loaded before they are sampled.
// ---------------------------------------------------------------------------
module value_noise_3d_octave_sum #(
  parameter int MAX_OCTAVES = vno_pkg::MAX_OCTAVES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [vno_pkg::FREQ_W-1:0] cfg_wdata_i,
  vno_in_if.sink                     in_i,
  vno_out_if.source                  out_o
);
  import vno_pkg::*;

  localparam int NSTG  = 7;
  localparam int SUM_W = 20 + $clog2(MAX_OCTAVES);

  // Configuration
  logic [OCT_CNT_W-1:0] octave_count_q;
  logic [FREQ_W-1:0]    base_freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= OCT_CNT_RST;
      base_freq_q    <= FREQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OCTAVE_COUNT: octave_count_q <= cfg_wdata_i[OCT_CNT_W-1:0];
        REG_BASE_FREQ:    base_freq_q    <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves
  logic [NSTG:1]   vld_q;
  logic [NSTG+1:1] en;
  logic            out_vld_q;

  always_comb begin
    en[NSTG+1] = !out_vld_q || out_o.ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[1];

  logic func1_q, func2_q, func3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[1]) vld_q[1] <= in_i.valid;
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      // loads end at the memory stage
      if (en[4]) vld_q[4] <= vld_q[3] && func3_q;
      for (int k = 5; k <= NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
      if (en[NSTG+1]) out_vld_q <= vld_q[NSTG];
    end
  end

  // Stage 1: partial products of coordinate and base frequency
  logic [PROD_W-1:0]     mxl1_q, mxh1_q, myl1_q, myh1_q;
  logic [COORD_Z_W-1:0]  cz1_q, cz2_q;
  logic [LD_OCT_W-1:0]   oct1_q, oct2_q;
  logic [LD_IDX_W-1:0]   idx1_q, idx2_q;
  logic [VAL_W-1:0]      lval1_q, lval2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      func1_q <= in_i.func;
      oct1_q  <= in_i.load_octave;
      idx1_q  <= in_i.load_index;
      lval1_q <= in_i.load_value;
      cz1_q   <= in_i.coord_z;
      mxl1_q  <= PROD_W'(in_i.coord_x[HALF_W-1:0]) * PROD_W'(base_freq_q);
      mxh1_q  <= PROD_W'(in_i.coord_x[COORD_XY_W-1:HALF_W]) * PROD_W'(base_freq_q);
      myl1_q  <= PROD_W'(in_i.coord_y[HALF_W-1:0]) * PROD_W'(base_freq_q);
      myh1_q  <= PROD_W'(in_i.coord_y[COORD_XY_W-1:HALF_W]) * PROD_W'(base_freq_q);
    end
  end

  // Stage 2: combine partials, kept modulo 2^PROD_W
  logic [PROD_W-1:0] prx2_q, pry2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      func2_q <= func1_q;
      oct2_q  <= oct1_q;
      idx2_q  <= idx1_q;
      lval2_q <= lval1_q;
      cz2_q   <= cz1_q;
      prx2_q  <= mxl1_q + {mxh1_q[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
      pry2_q  <= myl1_q + {myh1_q[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  // Stage 3: load fields split into bank and bank address
  logic [LD_OCT_W-1:0] oct3_q;
  logic [2:0]          lbank3_q;
  logic [BANK_AW-1:0]  laddr3_q;
  logic [VAL_W-1:0]    lval3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      func3_q  <= func2_q;
      oct3_q   <= oct2_q;
      lval3_q  <= lval2_q;
      lbank3_q <= {idx2_q[2*LAT_BITS], idx2_q[LAT_BITS], idx2_q[0]};
      laddr3_q <= {idx2_q[3*LAT_BITS-1:2*LAT_BITS+1],
                   idx2_q[2*LAT_BITS-1:LAT_BITS+1],
                   idx2_q[LAT_BITS-1:1]};
    end
  end

  logic signed [VAL_W-1:0] zb7_q [MAX_OCTAVES];

  // One lane per octave
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    logic [PROD_W-1:0]   pxs, pys;
    logic [LAT_BITS-1:0] x0, y0, z0;
    logic [FRAC_W-1:0]   fx, fy, fz;

    assign pxs = prx2_q >> (FRAC_W - i);
    assign pys = pry2_q >> (FRAC_W - i);
    assign fx  = pxs[FRAC_W-1:0];
    assign fy  = pys[FRAC_W-1:0];
    assign fz  = cz2_q[FRAC_W-1:0];
    assign x0  = pxs[FRAC_W+LAT_BITS-1:FRAC_W];
    assign y0  = pys[FRAC_W+LAT_BITS-1:FRAC_W];
    assign z0  = cz2_q[FRAC_W+LAT_BITS-1:FRAC_W];

    logic [BANK_AW-1:0] addr3_q [NBANK];
    logic [2:0]         par3_q, par4_q;
    logic [W_W-1:0]     wx3_q, wy3_q, wz3_q;
    logic [W_W-1:0]     wy4_q, wz4_q, wx4_q, wy5_q, wz5_q, wz6_q;
    logic [VAL_W-1:0]   rd4_q [NBANK];

    // Stage 3: per-bank corner addresses and weights
    always_ff @(posedge clk_i) begin
      if (en[3]) begin
        par3_q <= {y0[0], x0[0], z0[0]};
        wx3_q  <= WEIGHT_TAB[fx[FRAC_W-1 -: COS_BITS]];
        wy3_q  <= WEIGHT_TAB[fy[FRAC_W-1 -: COS_BITS]];
        wz3_q  <= WEIGHT_TAB[fz[FRAC_W-1 -: COS_BITS]];
      end
    end

    for (genvar b = 0; b < NBANK; b++) begin : g_bank
      localparam logic BY = 1'((b >> 2) & 1);
      localparam logic BX = 1'((b >> 1) & 1);
      localparam logic BZ = 1'(b & 1);
      logic [LAT_BITS-1:0] xc, yc, zc;
      logic [VAL_W-1:0]    mem [BANK_DEPTH];
      logic                we, re;

      assign xc = x0 + LAT_BITS'(BX ^ x0[0]);
      assign yc = y0 + LAT_BITS'(BY ^ y0[0]);
      assign zc = z0 + LAT_BITS'(BZ ^ z0[0]);

      always_ff @(posedge clk_i) begin
        if (en[3]) begin
          addr3_q[b] <= {yc[LAT_BITS-1:1], xc[LAT_BITS-1:1], zc[LAT_BITS-1:1]};
        end
      end

      // Memory stage: loads write, samples read
      assign we = en[4] && vld_q[3] && !func3_q && (32'(oct3_q) == i)
                  && (lbank3_q == 3'(b));
      assign re = en[4] && vld_q[3] && func3_q;

      always_ff @(posedge clk_i) begin
        if (we) mem[laddr3_q] <= lval3_q;
        if (re) rd4_q[b] <= mem[addr3_q[b]];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[4]) begin
        par4_q <= par3_q;
        wx4_q  <= wx3_q;
        wy4_q  <= wy3_q;
        wz4_q  <= wz3_q;
      end
    end

    // Stage 4: route banks to corners {dy,dx,dz}, blend along x
    logic signed [VAL_W-1:0] corner [NBANK];
    logic signed [VAL_W-1:0] xb5_q [4];

    always_comb begin
      for (int c = 0; c < NBANK; c++) begin
        corner[c] = rd4_q[3'(c) ^ par4_q];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[5]) begin
        for (int j = 0; j < 4; j++) begin
          // j = {dy,dz}
          xb5_q[j] <= blend(corner[{j[1], 1'b0, j[0]}], corner[{j[1], 1'b1, j[0]}],
                            wx4_q);
        end
        wy5_q <= wy4_q;
        wz5_q <= wz4_q;
      end
    end

    // Stage 5: blend along y
    logic signed [VAL_W-1:0] lo6_q, hi6_q;

    always_ff @(posedge clk_i) begin
      if (en[6]) begin
        lo6_q <= blend(xb5_q[0], xb5_q[2], wy5_q);
        hi6_q <= blend(xb5_q[1], xb5_q[3], wy5_q);
        wz6_q <= wz5_q;
      end
    end

    // Stage 6: blend along z
    always_ff @(posedge clk_i) begin
      if (en[7]) begin
        zb7_q[i] <= blend(lo6_q, hi6_q, wz6_q);
      end
    end
  end

  // Stage 7: octave sum with saturation into the output register
  logic signed [SUM_W-1:0]   sum;
  logic signed [NOISE_W-1:0] sat;
  logic signed [NOISE_W-1:0] noise_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (i < int'(octave_count_q)) begin
        sum = sum + SUM_W'(zb7_q[i]);
      end
    end
    if (sum > SUM_W'(NOISE_MAX)) begin
      sat = NOISE_W'(NOISE_MAX);
    end else if (sum < SUM_W'(NOISE_MIN)) begin
      sat = NOISE_W'(NOISE_MIN);
    end else begin
      sat = sum[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG+1]) noise_q <= sat;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.noise_value = noise_q;

endmodule

// ===== tb/tb_value_noise_3d_octave_sum.sv =====
// ---------------------------------------------------------------------------
// tb_value_noise_3d_octave_sum
// Self-checking bench for the 3D value noise octave summer. Lattice words are
// loaded before any sample reads them, then directed and random load/sample
// words run under several idling and stall patterns. A scoreboard predicts
// each noise result and checks the results in order.
// ---------------------------------------------------------------------------
module tb_value_noise_3d_octave_sum;
  timeunit 1ns;
  timeprecision 1ps;
  import vno_pkg::*;

  localparam int  SIDE      = 32;
  localparam int  CELL_CNT  = SIDE * SIDE * SIDE;
  localparam int  OCT_LANES = 8;
  localparam int  TBL_DEPTH = 256;
  localparam int  LIMIT     = 3_000_000;
  localparam int  PHASE_WORDS = 350;
  localparam bit  FN_LOAD   = 1'b0;
  localparam bit  FN_SAMPLE = 1'b1;

  // Noise predictor and store of expected sums
  class noise_scoreboard;
    shortint lattice [OCT_LANES][CELL_CNT];
    longint  wtab [TBL_DEPTH];
    int      oct_cnt;
    longint  base_freq;
    logic signed [NOISE_W-1:0] exp_sums [$];
    int      errors;
    int      samples_seen;

    function new();
      longint pi30, one30, u, m, u2, t, s, w;
      pi30 = 64'd3373259426;
      one30 = 64'd1073741824;
      // (1 + cos(pi*k/256))/2, Q1.16, from a Q30 sine series
      for (int k = 0; k < TBL_DEPTH; k++) begin
        u  = (pi30 * (2 * longint'(k) - TBL_DEPTH)) / (2 * TBL_DEPTH);
        m  = (u < 0) ? -u : u;
        u2 = (m * m) >> 30;
        t  = one30 - u2 / 110;
        t  = one30 - ((u2 * t) >> 30) / 72;
        t  = one30 - ((u2 * t) >> 30) / 42;
        t  = one30 - ((u2 * t) >> 30) / 20;
        t  = one30 - ((u2 * t) >> 30) / 6;
        s  = (m * t) >> 30;
        if (u < 0) s = -s;
        w  = one30 - s + 16384;
        if (w < 0) w = 0;
        w  = w / 32768;
        if (w > 65536) w = 65536;
        wtab[k] = w;
      end
      oct_cnt   = 1;
      base_freq = 65536;
      errors    = 0;
      samples_seen = 0;
    endfunction

    function longint mix(longint a, longint b, longint frac);
      longint w;
      w = wtab[(frac & 16'hFFFF) >> 8];
      return b + (((a - b) * w + 32768) >>> 16);
    endfunction

    function longint corner(int o, longint x, longint y, longint z);
      return lattice[o][(y % SIDE) * SIDE * SIDE + (x % SIDE) * SIDE + (z % SIDE)];
    endfunction

    function longint octave_sum(int o, longint cx, longint cy, longint cz);
      longint px, py, x0, y0, z0, x1, y1, z1, fx, fy, fz, a, b, c, d;
      px = (cx * base_freq) >> (16 - o);
      py = (cy * base_freq) >> (16 - o);
      fx = px & 16'hFFFF; fy = py & 16'hFFFF; fz = cz & 16'hFFFF;
      x0 = (px >> 16) % SIDE; y0 = (py >> 16) % SIDE; z0 = (cz >> 16) % SIDE;
      x1 = (x0 + 1) % SIDE; y1 = (y0 + 1) % SIDE; z1 = (z0 + 1) % SIDE;
      a = mix(corner(o, x0, y0, z0), corner(o, x1, y0, z0), fx);
      b = mix(corner(o, x0, y1, z0), corner(o, x1, y1, z0), fx);
      c = mix(corner(o, x0, y0, z1), corner(o, x1, y0, z1), fx);
      d = mix(corner(o, x0, y1, z1), corner(o, x1, y1, z1), fx);
      return mix(mix(a, b, fy), mix(c, d, fy), fz);
    endfunction

    // Accepted input word
    function void note_word(bit fn, int oct, int idx, shortint val,
                            longint cx, longint cy, longint cz);
      longint sum;
      int n;
      if (fn == FN_LOAD) begin
        lattice[oct][idx] = val;
        return;
      end
      n = (oct_cnt < OCT_LANES) ? oct_cnt : OCT_LANES;
      sum = 0;
      for (int o = 0; o < n; o++) sum += octave_sum(o, cx, cy, cz);
      if (sum > NOISE_MAX) sum = NOISE_MAX;
      if (sum < NOISE_MIN) sum = NOISE_MIN;
      exp_sums.push_back(NOISE_W'(sum));
    endfunction

    // Accepted result word
    function void check_sum(logic signed [NOISE_W-1:0] got);
      logic signed [NOISE_W-1:0] want;
      samples_seen++;
      if (exp_sums.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d", got);
        return;
      end
      want = exp_sums.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("noise_value mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [FREQ_W-1:0] cfg_wdata_i;

  vno_in_if  in_if();
  vno_out_if out_if();

  value_noise_3d_octave_sum i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i(in_if), .out_o(out_if)
  );

  noise_scoreboard sb = new();
  int  send_idle_pct  = 0;
  int  sink_stall_pct = 0;
  int  hold_req       = 0;
  longint cycles      = 0;
  int  words_sent     = 0;
  // Lattice entries already written by an accepted load
  bit  loaded [OCT_LANES][CELL_CNT];

  always #1 clk_i = ~clk_i;

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** value_noise_3d_octave_sum: FAILED **");
      $finish;
    end
  end

  // Monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_word(in_if.func, in_if.load_octave, in_if.load_index, in_if.load_value,
                   in_if.coord_x, in_if.coord_y, in_if.coord_z);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_sum(out_if.noise_value);
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one word and wait for its acceptance, with an optional gap after
  task automatic send_word(bit fn, int oct, int idx, int val,
                           int cx, int cy, int cz);
    in_if.valid       <= 1'b1;
    in_if.func        <= fn;
    in_if.load_octave <= LD_OCT_W'(oct);
    in_if.load_index  <= LD_IDX_W'(idx);
    in_if.load_value  <= VAL_W'(val);
    in_if.coord_x     <= COORD_XY_W'(cx);
    in_if.coord_y     <= COORD_XY_W'(cy);
    in_if.coord_z     <= COORD_Z_W'(cz);
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    if (fn == FN_LOAD) loaded[oct & 7][idx & 16'h7FFF] = 1'b1;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // Load every lattice word that a sample at this point reads and that is unwritten
  task automatic load_corners(int cx, int cy, int cz);
    longint px, py, zi0;
    int n, xi, yi, zi, pos;
    n   = (sb.oct_cnt < OCT_LANES) ? sb.oct_cnt : OCT_LANES;
    zi0 = (longint'(cz) & 64'h1FFFFF) >> 16;
    for (int o = 0; o < n; o++) begin
      px = ((longint'(cx) & 64'h3FFFFFF) * sb.base_freq) >> (16 - o);
      py = ((longint'(cy) & 64'h3FFFFFF) * sb.base_freq) >> (16 - o);
      for (int c = 0; c < 8; c++) begin
        xi  = int'(((px >> 16) + ((c >> 1) & 1)) % SIDE);
        yi  = int'(((py >> 16) + ((c >> 2) & 1)) % SIDE);
        zi  = int'((zi0 + (c & 1)) % SIDE);
        pos = yi * SIDE * SIDE + xi * SIDE + zi;
        if (!loaded[o][pos])
          send_word(FN_LOAD, o, pos, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic send_sample(int cx, int cy, int cz);
    load_corners(cx, cy, cz);
    send_word(FN_SAMPLE, $urandom, $urandom, $urandom, cx, cy, cz);
  endtask

  // Upper x/y bound for near samples: the top octave's cell index stays at most two
  function automatic int near_limit();
    longint n;
    longint lim;
    n = (sb.oct_cnt < 1) ? 1 : (sb.oct_cnt > OCT_LANES) ? OCT_LANES : sb.oct_cnt;
    if (sb.base_freq == 0) return 26'h3FFFFFF;
    lim = (64'd1 << (34 - n)) / sb.base_freq;
    if (lim < 1) lim = 1;
    return (lim > 26'h3FFFFFF) ? 26'h3FFFFFF : int'(lim);
  endfunction

  task automatic send_random();
    int lim;
    lim = near_limit();
    if ($urandom_range(99) < 30)
      send_word(FN_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if ($urandom_range(99) < 80)
      send_sample($urandom_range(lim), $urandom_range(lim), $urandom_range(17'h1FFFF));
    else
      send_sample($urandom, $urandom, $urandom);
  endtask

  // Wait until the pipeline is empty
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.exp_sums.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= FREQ_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_OCTAVE_COUNT) sb.oct_cnt = value & 4'hF;
    else                         sb.base_freq = value & 24'hFFFFFF;
    @(posedge clk_i);
  endtask

  task automatic set_config(int oc, int bf);
    drain();
    write_reg(REG_OCTAVE_COUNT, oc);
    write_reg(REG_BASE_FREQ, bf);
  endtask

  initial begin
    int oc;
    int bf;
    int start;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = 1'b0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.func   = FN_LOAD;
    in_if.load_octave = '0;
    in_if.load_index  = '0;
    in_if.load_value  = '0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme cells in every octave: cell 0 at the minimum, cell 1 at the maximum
    for (int o = 0; o < OCT_LANES; o++) begin
      send_word(FN_LOAD, o, 0, -32768, $urandom, $urandom, $urandom);
      send_word(FN_LOAD, o, 1, 32767, $urandom, $urandom, $urandom);
    end

    // Directed: reset settings, coordinate extremes
    send_sample(0, 0, 0);
    send_sample(26'h3FFFFFF, 26'h3FFFFFF, 21'h1FFFFF);
    send_sample(32'h8000, 32'h18000, 32'h4000);
    // All eight octaves on the extreme cells: full negative sum and near max
    set_config(8, 65536);
    send_sample(0, 0, 0);
    send_sample(0, 0, 65536);
    send_sample(26'h3FFFFFF, 0, 21'h1FFFFF);
    // Octave count zero gives zero; counts above eight are limited
    set_config(0, 65536);
    send_sample(12345, 678, 9012);
    set_config(15, 24'hFFFFFF);
    send_sample(26'h3FFFFFF, 26'h3FFFFFF, 21'h1FFFFF);
    send_sample(1, 1, 1);
    set_config(3, 0);
    send_sample(26'h2AAAAAA, 26'h1555555, 21'h0AAAAA);
    // A sample ignores load fields; a load ignores coordinates
    load_corners(70000, 80000, 90000);
    send_word(FN_SAMPLE, 7, 32767, -1, 70000, 80000, 90000);
    send_word(FN_LOAD, 7, 32767, 16'sh4000, 26'h3FFFFFF, 0, 0);
    send_sample(26'h1F0000, 26'h1F0000, 21'h1F0000);

    // Random phases: a long receiver hold-off only, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      oc = $urandom_range(15);
      bf = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20'hFFFFF);
      if (ph == 3) oc = 8;
      set_config(oc, bf);
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 48) : 0;
      sink_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 48) : 0;
      if (ph == 0) hold_req++;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) send_random();
      if (ph == 1) hold_req++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.exp_sums.size() != 0) begin
      sb.errors++;
      $display("%0d expected results never arrived", sb.exp_sums.size());
    end
    $display("Covered: %0d words in all, lattice loaded ahead of use, %0d noise results,",
             words_sent, sb.samples_seen);
    $display("octave counts 0..15, frequency extremes, idling and long back-pressure");
    if (sb.errors == 0) begin
      $display("** value_noise_3d_octave_sum: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** value_noise_3d_octave_sum: FAILED **");
    end
    $finish;
  end

endmodule

// ===== value_noise_3d_octave_sum.f =====
rtl/vno_pkg.sv
rtl/vno_if.sv
rtl/value_noise_3d_octave_sum.sv
tb/tb_value_noise_3d_octave_sum.sv
